// ----- rtl/lossless_jpeg_raw_encoder_core_defines.svh -----
// assertion macros used by the checker file
`ifndef LOSSLESS_JPEG_RAW_ENCODER_CORE_DEFINES_SVH
`define LOSSLESS_JPEG_RAW_ENCODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LJRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define LJRE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ljre_pkg.sv -----
`default_nettype none

package ljre_pkg;

  // configuration register indexes
  localparam logic CFG_ROW_WIDTH     = 1'b0;
  localparam logic CFG_CODE_RANK_MAP = 1'b1;

  localparam int CFG_DATA_W = 52;
  localparam logic [15:0] ROW_WIDTH_RST = 16'd1;
  localparam logic [51:0] RANK_MAP_RST  = 52'hCBA9876543210;

  // pending bit string: up to 7 held bits plus 10 prefix bits plus 12 value bits
  localparam int PEND_W = 29;
  localparam int CNT_W  = 5;
  localparam int WORD_W = 22;

  localparam logic [3:0] LAST_RANK = 4'd12;
  localparam logic [7:0] BYTE_FF   = 8'hFF;

  // byte phases of the packed sample stream
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_THIRD  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENCODE,
    S_EMIT,
    S_STUFF
  } ljre_state_t;

  typedef struct packed {
    logic accept;
    logic encode;
    logic emit;
    logic stuff;
  } ljre_cmd_t;

  typedef struct packed {
    logic will_encode;
    logic cnt_ge8;
    logic top_ff;
    logic more;
    logic slot_free;
  } ljre_status_t;

  function automatic logic [9:0] prefix_code(input logic [3:0] rank);
    logic [9:0] c;
    case (rank)
      4'd0:    c = 10'h000;
      4'd1:    c = 10'h001;
      4'd2:    c = 10'h004;
      4'd3:    c = 10'h005;
      4'd4:    c = 10'h006;
      4'd5:    c = 10'h00E;
      4'd6:    c = 10'h01E;
      4'd7:    c = 10'h03E;
      4'd8:    c = 10'h07E;
      4'd9:    c = 10'h0FE;
      4'd10:   c = 10'h1FE;
      4'd11:   c = 10'h3FE;
      default: c = 10'h3FF;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] prefix_len(input logic [3:0] rank);
    logic [3:0] l;
    case (rank)
      4'd0, 4'd1:       l = 4'd2;
      4'd2, 4'd3, 4'd4: l = 4'd3;
      4'd5:             l = 4'd4;
      4'd6:             l = 4'd5;
      4'd7:             l = 4'd6;
      4'd8:             l = 4'd7;
      4'd9:             l = 4'd8;
      4'd10:            l = 4'd9;
      default:          l = 4'd10;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lossless_jpeg_raw_encoder_core.sv -----
// a sample-completing byte passes through ENCODE and EMIT before its first coded byte
//   reaches the output register; the first byte of a sample triple is taken in IDLE with
//   no encode; the emit loop passes once per coded byte (stuffed zeros included) and
//   output stalls hold it; no new raw byte is taken until the loop returns to IDLE
// reset: rst_n synchronous, active low; predictors to mid-scale, packer empty,
//   configuration registers to their defaults
`default_nettype none

module lossless_jpeg_raw_encoder_core #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes, only while no item is in flight
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [ljre_pkg::CFG_DATA_W-1:0] cfg_data,
  // packed raw byte stream
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_raw_byte,
  // coded byte stream
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_is_last
);

  // controller sequences accept, encode and the byte emit loop;
  // the datapath holds predictors, bit packer and the output register
  ljre_pkg::ljre_cmd_t    cmd;
  ljre_pkg::ljre_status_t status;

  ljre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // one output register parts the emit loop from the consumer, so the last
  // coded byte of an item may still wait while the next item is taken
  ljre_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_raw_byte (in_raw_byte),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_is_last (out_is_last)
  );

endmodule

`default_nettype wire

// ----- rtl/ljre_ctrl.sv -----
`default_nettype none

module ljre_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  ljre_pkg::ljre_status_t status,
  output ljre_pkg::ljre_cmd_t    cmd,
  output logic                  in_stall
);

  ljre_pkg::ljre_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ljre_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ljre_pkg::S_IDLE: begin
        if (in_valid && status.will_encode) state_nxt = ljre_pkg::S_ENCODE;
      end
      ljre_pkg::S_ENCODE: begin
        state_nxt = ljre_pkg::S_EMIT;
      end
      ljre_pkg::S_EMIT: begin
        if (!status.cnt_ge8) begin
          state_nxt = ljre_pkg::S_IDLE;
        end else if (status.slot_free) begin
          if (status.top_ff)    state_nxt = ljre_pkg::S_STUFF;
          else if (status.more) state_nxt = ljre_pkg::S_EMIT;
          else                  state_nxt = ljre_pkg::S_IDLE;
        end
      end
      ljre_pkg::S_STUFF: begin
        if (status.slot_free) begin
          state_nxt = status.cnt_ge8 ? ljre_pkg::S_EMIT : ljre_pkg::S_IDLE;
        end
      end
      default: state_nxt = ljre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ljre_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ljre_pkg::S_ENCODE: cmd.encode = 1'b1;
      ljre_pkg::S_EMIT:   cmd.emit   = status.cnt_ge8 && status.slot_free;
      ljre_pkg::S_STUFF:  cmd.stuff  = status.slot_free;
      default:            cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ljre_dp.sv -----
`default_nettype none

module ljre_dp #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [ljre_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]                       in_raw_byte,
  input  logic                             out_stall,
  input  ljre_pkg::ljre_cmd_t              cmd,
  output ljre_pkg::ljre_status_t           status,
  output logic                             out_valid,
  output logic [7:0]                       out_byte,
  output logic                             out_is_last
);

  localparam int SB = SAMPLE_BITS;
  localparam int PW = ljre_pkg::PEND_W;
  localparam int CW = ljre_pkg::CNT_W;
  localparam logic [SB-1:0] PRED_RST = SB'(1) << (SB - 1);

  logic [15:0] row_width_r;
  logic [51:0] rank_map_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  held_r;
  logic [SB-1:0] pixel_r, pixel_nxt;
  logic [SB-1:0] left_r [2];
  logic [SB-1:0] left_nxt [2];
  logic [SB-1:0] rs_r [2];
  logic [SB-1:0] rs_nxt [2];
  logic [15:0] col_r, col_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  // sample assembly
  logic [11:0] pix12;
  logic [15:0] pix_wide;

  always_comb begin
    pix12    = (phase_r == ljre_pkg::PH_SECOND) ? {held_r, in_raw_byte[7:4]}
                                                : {held_r[3:0], in_raw_byte};
    pix_wide = {4'b0, pix12};
    pixel_nxt = pix_wide[SB-1:0];
    if (phase_r == ljre_pkg::PH_SECOND)     phase_nxt = ljre_pkg::PH_THIRD;
    else if (phase_r == ljre_pkg::PH_THIRD) phase_nxt = ljre_pkg::PH_FIRST;
    else                                    phase_nxt = ljre_pkg::PH_SECOND;
  end

  // difference, category and code word
  logic signed [SB:0]  diff;
  logic signed [16:0]  d17;
  logic signed [12:0]  dsat;
  logic [12:0]         mag;
  logic [12:0]         vbits;
  logic [3:0]          cat;
  logic [3:0]          rank;
  logic [9:0]          code;
  logic [CW-1:0]       tot;
  logic [ljre_pkg::WORD_W-1:0] word;

  always_comb begin
    diff = $signed({1'b0, pixel_r}) - $signed({1'b0, left_r[0]});
    d17  = 17'(diff);
    if (d17 > 17'sd4095)       dsat = 13'sd4095;
    else if (d17 < -17'sd4095) dsat = -13'sd4095;
    else                       dsat = d17[12:0];
    mag = dsat[12] ? 13'(-dsat) : dsat;
    cat = '0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) cat = 4'(i + 1);
    end
    rank = rank_map_r[{cat, 2'b00} +: 4];
    if (rank > ljre_pkg::LAST_RANK) rank = ljre_pkg::LAST_RANK;
    code  = ljre_pkg::prefix_code(rank);
    vbits = (dsat[12] ? 13'(dsat - 13'sd1) : dsat) & ((13'd1 << cat) - 13'd1);
    word  = ({12'b0, code} << cat) | {10'b0, vbits[11:0]};
    tot   = CW'(ljre_pkg::prefix_len(rank)) + CW'(cat);
  end

  // byte extraction from the pending bits
  logic [CW-1:0] rem;
  logic [7:0]    top;

  always_comb begin
    rem = cnt_r - CW'(8);
    top = 8'(pend_r >> rem);
    status.will_encode = (phase_r == ljre_pkg::PH_SECOND) ||
                         (phase_r == ljre_pkg::PH_THIRD);
    status.cnt_ge8   = cnt_r >= CW'(8);
    status.top_ff    = top == ljre_pkg::BYTE_FF;
    status.more      = rem >= CW'(8);
    status.slot_free = !out_valid_r || !out_stall;
  end

  // predictor and row bookkeeping
  logic col_end;

  always_comb begin
    col_end   = ({1'b0, col_r} + 17'd1) >= {1'b0, row_width_r};
    rs_nxt[0] = rs_r[0];
    rs_nxt[1] = rs_r[1];
    if (col_r < 16'd2) rs_nxt[col_r[0]] = pixel_r;
    if (col_end) begin
      left_nxt[0] = rs_nxt[0];
      left_nxt[1] = rs_nxt[1];
      col_nxt     = '0;
    end else begin
      left_nxt[0] = left_r[1];
      left_nxt[1] = pixel_r;
      col_nxt     = col_r + 16'd1;
    end
  end

  // bit packing and output register
  always_comb begin
    pend_nxt      = pend_r;
    cnt_nxt       = cnt_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.encode) begin
      pend_nxt = (pend_r << tot) | PW'(word);
      cnt_nxt  = cnt_r + tot;
    end
    if (cmd.emit) begin
      out_byte_nxt  = top;
      out_last_nxt  = !status.top_ff && !status.more;
      out_valid_nxt = 1'b1;
      pend_nxt      = pend_r & ((PW'(1) << rem) - PW'(1));
      cnt_nxt       = rem;
    end
    if (cmd.stuff) begin
      out_byte_nxt  = '0;
      out_last_nxt  = !status.cnt_ge8;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ljre_pkg::ROW_WIDTH_RST;
      rank_map_r  <= ljre_pkg::RANK_MAP_RST;
      phase_r     <= ljre_pkg::PH_FIRST;
      held_r      <= '0;
      left_r[0]   <= PRED_RST;
      left_r[1]   <= PRED_RST;
      rs_r[0]     <= '0;
      rs_r[1]     <= '0;
      col_r       <= '0;
      pend_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ljre_pkg::CFG_ROW_WIDTH:     row_width_r <= cfg_data[15:0];
          ljre_pkg::CFG_CODE_RANK_MAP: rank_map_r  <= cfg_data;
          default:                     rank_map_r  <= rank_map_r;
        endcase
      end
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        held_r  <= in_raw_byte;
      end
      if (cmd.encode) begin
        left_r[0] <= left_nxt[0];
        left_r[1] <= left_nxt[1];
        rs_r[0]   <= rs_nxt[0];
        rs_r[1]   <= rs_nxt[1];
        col_r     <= col_nxt;
      end
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) pixel_r <= pixel_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_is_last = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/ljre_checker.sv -----
`default_nettype none
`include "lossless_jpeg_raw_encoder_core_defines.svh"

module ljre_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_raw_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_is_last
);

  logic out_take;
  logic in_take;

  assign out_take = out_valid && !out_stall;
  assign in_take  = in_valid && !in_stall && (in_raw_byte == in_raw_byte);

  // a stalled item stays offered unchanged
  `LJRE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_is_last), "stalled output item changed")

  // a taken 0xff is followed at once by its stuffed zero
  `LJRE_ASSERT_NXT(a_stuff_follows, out_take && out_byte == 8'hFF, out_valid && out_byte == 8'h00, "no stuffed zero after 0xff")

  // an item never ends on a 0xff
  `LJRE_ASSERT_IMP(a_ff_not_last, out_valid && out_byte == 8'hFF, !out_is_last, "0xff marked as last byte")

  // while input is open, any waiting byte closes the previous item
  `LJRE_ASSERT_IMP(a_idle_last, out_valid && (!in_stall || in_take), out_is_last, "input open with bytes pending")

endmodule

bind lossless_jpeg_raw_encoder_core ljre_checker u_ljre_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_raw_byte (in_raw_byte),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .out_is_last (out_is_last)
);

`default_nettype wire

// ----- dv/tb_lossless_jpeg_raw_encoder_core.sv -----
`default_nettype none

module tb_lossless_jpeg_raw_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  // one coded byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } coded_t;

  // fixed prefix table indexed by rank, codes right-aligned
  localparam logic [9:0] RANK_CODE [13] = '{
    10'h000, 10'h001, 10'h004, 10'h005, 10'h006, 10'h00E, 10'h01E,
    10'h03E, 10'h07E, 10'h0FE, 10'h1FE, 10'h3FE, 10'h3FF
  };
  localparam int RANK_LEN [13] = '{2, 2, 3, 3, 3, 4, 5, 6, 7, 8, 9, 10, 10};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_we = 1'b0;
  logic                            cfg_index = ljre_pkg::CFG_ROW_WIDTH;
  logic [ljre_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_raw_byte = 8'h00;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_last;

  // idling switches and the receiver hold-off request
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_len = 0;
  int hold_tag = 0;
  int seen_tag = 0;
  int hold_left = 0;

  // bookkeeping
  int err_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int reg_writes = 0;

  // coded bytes still owed by the block, oldest first
  coded_t coded_q [$];

  // predictor copy of the configuration
  logic [15:0] cur_row_width;
  logic [51:0] cur_rank_map;

  // predictor copy of the block state
  logic [1:0]  pk_phase;
  logic [7:0]  pk_held;
  logic [11:0] pred_left [2];
  logic [11:0] row_first [2];
  logic [15:0] col_pos;
  logic [7:0]  bit_acc;
  logic [2:0]  bit_cnt;

  lossless_jpeg_raw_encoder_core #(.SAMPLE_BITS(12)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_raw_byte (in_raw_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_is_last (out_is_last)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------

  task automatic predictor_reset();
    cur_row_width = ljre_pkg::ROW_WIDTH_RST;
    cur_rank_map  = ljre_pkg::RANK_MAP_RST;
    pk_phase      = ljre_pkg::PH_FIRST;
    pk_held       = 8'h00;
    pred_left[0]  = 12'h800;
    pred_left[1]  = 12'h800;
    row_first[0]  = 12'h000;
    row_first[1]  = 12'h000;
    col_pos       = 16'd0;
    bit_acc       = 8'h00;
    bit_cnt       = 3'd0;
  endtask

  // bit packer, msb first, a zero byte stuffed after every 0xff
  task automatic pack_bit(input logic b);
    bit_acc = {bit_acc[6:0], b};
    bit_cnt = bit_cnt + 3'd1;
    if (bit_cnt == 3'd0) begin
      coded_q.push_back(coded_t'{data: bit_acc, is_last: 1'b0});
      if (bit_acc == ljre_pkg::BYTE_FF) begin
        coded_q.push_back(coded_t'{data: 8'h00, is_last: 1'b0});
      end
      bit_acc = 8'h00;
    end
  endtask

  task automatic pack_field(input int count, input logic [11:0] value);
    for (int i = count - 1; i >= 0; i--) pack_bit(value[i]);
  endtask

  task automatic code_sample(input logic [11:0] pixel);
    int          diff;
    int          mag;
    int          cat;
    logic [3:0]  rank;
    logic [11:0] tail;
    diff = int'(pixel) - int'(pred_left[0]);
    mag  = (diff < 0) ? -diff : diff;
    cat  = 0;
    while (mag != 0) begin
      mag = mag >> 1;
      cat++;
    end
    // ranks past the end of the table fall back to the last code
    rank = cur_rank_map[4*cat +: 4];
    if (rank > ljre_pkg::LAST_RANK) rank = ljre_pkg::LAST_RANK;
    pack_field(RANK_LEN[rank], {2'b00, RANK_CODE[rank]});
    // negative differences go out one's-complement style
    tail = (diff < 0) ? 12'(diff - 1) : 12'(diff);
    pack_field(cat, tail);

    pred_left[0] = pred_left[1];
    pred_left[1] = pixel;
    if (col_pos < 16'd2) row_first[col_pos[0]] = pixel;
    // zero width and a width shrunk mid-row both end the row here
    if ({1'b0, col_pos} + 17'd1 >= {1'b0, cur_row_width}) begin
      col_pos      = 16'd0;
      pred_left[0] = row_first[0];
      pred_left[1] = row_first[1];
    end else begin
      col_pos = col_pos + 16'd1;
    end
  endtask

  // works out the coded bytes that one accepted raw byte releases
  task automatic predict_raw_byte(input logic [7:0] b);
    int     mark;
    coded_t tail_c;
    mark = coded_q.size();
    case (pk_phase)
      ljre_pkg::PH_SECOND: begin
        pk_phase = ljre_pkg::PH_THIRD;
        code_sample({pk_held, b[7:4]});
        pk_held = b;
      end
      ljre_pkg::PH_THIRD: begin
        pk_phase = ljre_pkg::PH_FIRST;
        code_sample({pk_held[3:0], b});
        pk_held = b;
      end
      default: begin
        pk_held  = b;
        pk_phase = ljre_pkg::PH_SECOND;
      end
    endcase
    if (coded_q.size() > mark) begin
      tail_c = coded_q[coded_q.size() - 1];
      tail_c.is_last = 1'b1;
      coded_q[coded_q.size() - 1] = tail_c;
    end
  endtask

  // ---------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------

  // offers one raw byte, waits for it to be taken, then predicts
  task automatic send_byte(input logic [7:0] b);
    while (tx_gaps && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_raw_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_raw_byte(b);
    items_sent++;
  endtask

  // register writes lower cfg_we again before returning, so cfg_we never toggles within one step
  task automatic write_reg(input logic idx, input logic [ljre_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == ljre_pkg::CFG_ROW_WIDTH) cur_row_width = val[15:0];
    else cur_rank_map = val[51:0];
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // waits for every owed byte, then covers a sample still in flight
  task automatic settle_block();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (coded_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [7:0] random_raw_byte();
    logic [7:0] picks [5];
    picks = '{8'h00, 8'hFF, 8'h80, 8'h0F, 8'hF0};
    if ($urandom_range(99) < 75) return 8'($urandom_range(255));
    return picks[$urandom_range(4)];
  endfunction

  // two samples near their predictors, so that every category turns up
  task automatic send_smooth_triple();
    int k;
    int s0;
    int s1;
    logic [11:0] a;
    logic [11:0] c;
    k  = $urandom_range(11);
    s0 = int'(pred_left[0]) + int'($urandom_range(2 * (1 << k))) - (1 << k);
    k  = $urandom_range(11);
    s1 = int'(pred_left[1]) + int'($urandom_range(2 * (1 << k))) - (1 << k);
    if (s0 < 0) s0 = 0;
    if (s0 > 4095) s0 = 4095;
    if (s1 < 0) s1 = 0;
    if (s1 > 4095) s1 = 4095;
    a = 12'(s0);
    c = 12'(s1);
    send_byte(a[11:4]);
    send_byte({a[3:0], c[11:8]});
    send_byte(c[7:0]);
  endtask

  task automatic send_mixed_bytes(input int n);
    int remaining;
    remaining = n;
    while (remaining > 0) begin
      if (pk_phase == ljre_pkg::PH_FIRST && remaining >= 3 && $urandom_range(99) < 60) begin
        send_smooth_triple();
        remaining -= 3;
      end else begin
        send_byte(random_raw_byte());
        remaining--;
      end
    end
  endtask

  // ---------------------------------------------------------------
  // receiver stall, with a long hold-off on request
  // ---------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_tag != seen_tag) begin
      seen_tag  <= hold_tag;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_gaps && ($urandom_range(99) < 19);
    end
  end

  // ---------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------

  always @(posedge clk) begin
    coded_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (coded_q.size() == 0) begin
        $display("%0t: coded byte with nothing owed, got %02h is_last %0b",
                 $time, out_byte, out_is_last);
        err_count++;
      end else begin
        exp_c = coded_q.pop_front();
        bytes_checked++;
        if (out_byte !== exp_c.data) begin
          $display("%0t: out_byte expected %02h got %02h", $time, exp_c.data, out_byte);
          err_count++;
        end
        if (out_is_last !== exp_c.is_last) begin
          $display("%0t: out_is_last expected %0b got %0b",
                   $time, exp_c.is_last, out_is_last);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // field extremes under reset settings, then out-of-table ranks, zero width,
  // narrow rows and a width shrunk in the middle of a row
  task automatic test_directed_extremes();
    logic [7:0] seq [$];
    // mid-scale samples give category zero against the reset predictor
    seq = '{8'h80, 8'h08, 8'h00, 8'hFF, 8'hFF, 8'hFF,
            8'h00, 8'h00, 8'h00, 8'hF0, 8'h0F, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    settle_block();

    // every rank nibble out of the table, zero row width
    write_reg(ljre_pkg::CFG_CODE_RANK_MAP, {ljre_pkg::CFG_DATA_W{1'b1}});
    write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFF);
    settle_block();

    // all categories on the shortest code, then shrink the row under way
    write_reg(ljre_pkg::CFG_CODE_RANK_MAP, 52'd0);
    write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd8);
    repeat (6) send_byte(random_raw_byte());
    settle_block();
    write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd3);
    repeat (3) send_byte(random_raw_byte());
    settle_block();
  endtask

  // random bytes over a spread of widths and rank maps; last pass idles nowhere
  task automatic test_config_sweep();
    logic [63:0] r64;
    for (int p = 0; p < 5; p++) begin
      r64 = {$urandom(), $urandom()};
      case (p)
        0: begin
          write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd1);
          write_reg(ljre_pkg::CFG_CODE_RANK_MAP, ljre_pkg::RANK_MAP_RST);
        end
        1: begin
          write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd2);
          write_reg(ljre_pkg::CFG_CODE_RANK_MAP, 52'd0);
        end
        2: begin
          write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd65535);
          write_reg(ljre_pkg::CFG_CODE_RANK_MAP, {ljre_pkg::CFG_DATA_W{1'b1}});
        end
        3: begin
          write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'($urandom_range(12, 3)));
          write_reg(ljre_pkg::CFG_CODE_RANK_MAP, r64[51:0]);
        end
        default: begin
          write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'($urandom_range(5, 1)));
          write_reg(ljre_pkg::CFG_CODE_RANK_MAP, r64[51:0]);
          tx_gaps = 1'b0;
          rx_gaps = 1'b0;
        end
      endcase
      send_mixed_bytes(32);
      settle_block();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // receiver holds off while the sender keeps pushing, so the input stalls
  task automatic test_output_hold_off();
    write_reg(ljre_pkg::CFG_ROW_WIDTH, 52'd4);
    hold_len = 300;
    hold_tag = hold_tag + 1;
    tx_gaps  = 1'b0;
    send_mixed_bytes(30);
    tx_gaps  = 1'b1;
    settle_block();
  endtask

  initial begin
    predictor_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_config_sweep();
    test_output_hold_off();
    settle_block();

    $display("covered %0d raw bytes and %0d coded bytes over %0d register writes",
             items_sent, bytes_checked, reg_writes);
    $display("row widths from zero to full scale, out-of-table ranks, output hold-off");
    if (err_count == 0 && coded_q.size() == 0) begin
      $display("lossless_jpeg_raw_encoder_core: match");
    end else begin
      if (coded_q.size() != 0) $display("%0d coded bytes never arrived", coded_q.size());
      $display("lossless_jpeg_raw_encoder_core: mismatch");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("lossless_jpeg_raw_encoder_core: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
